/* hw/rtl/mspc_pkg.sv */
package mspc_pkg;

  localparam int SPEED_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int IMAX_W   = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam int FRAC_W   = 8;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(256);
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = '0;
  localparam logic [IMAX_W-1:0] IMAX_RST       = IMAX_W'(65535);

  typedef enum logic [1:0] {
    CMD_EDGE   = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_TARGET = 2'd2,
    CMD_BRAKE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN    = 2'd0,
    REG_INTEG_GAIN   = 2'd1,
    REG_INTEGRAL_MAX = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DUTY_KEEP = 2'd0,
    DUTY_ZERO = 2'd1,
    DUTY_PI   = 2'd2
  } duty_op_t;

  // pin and status fields that ride along with the duty computation
  typedef struct packed {
    logic               bridge_a;
    logic               bridge_b;
    logic [SPEED_W-1:0] measured_speed;
    logic               braking;
  } status_t;

endpackage

/* hw/rtl/mspc_if.sv */
interface mspc_item_if import mspc_pkg::*; ();
  logic                valid;
  logic                ready;
  cmd_t                command;
  logic [SPEED_W-1:0]  target_speed;
  logic                target_direction;
  logic                brake_request;

  modport source (output valid, command, target_speed, target_direction, brake_request,
                  input ready);
  modport sink (input valid, command, target_speed, target_direction, brake_request,
                output ready);
endinterface

interface mspc_result_if import mspc_pkg::*; #(parameter int DUTY_W = 10) ();
  logic                valid;
  logic                ready;
  logic [DUTY_W-1:0]   pwm_duty;
  logic                bridge_a;
  logic                bridge_b;
  logic [SPEED_W-1:0]  measured_speed;
  logic                braking;

  modport source (output valid, pwm_duty, bridge_a, bridge_b, measured_speed, braking,
                  input ready);
  modport sink (input valid, pwm_duty, bridge_a, bridge_b, measured_speed, braking,
                output ready);
endinterface

interface mspc_cfg_if import mspc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  reg_idx_t              index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/motor_speed_pi_controller_unit.sv */
// Motor speed PI controller.
// item (sink): one command word per handshake: encoder edge, period tick,
//   new target (speed and direction) or brake set/clear.
// result (source): one word per accepted item, showing pwm_duty, the two
//   bridge pin levels, the last measured speed and the brake state after it.
// cfg (sink): register writes (0 prop_gain, 1 integ_gain, 2 integral_max),
//   always ready; write only while no item is in flight.
// Throughput: one item per cycle, sustained while result.ready stays high.
// An accepted word passes through the input register, the state update /
//   error stage, the multiplier stage, then the sum/saturate stage that
//   loads the result register, before it is shown on result.
// Every stage holds a valid bit; ready ripples back, so empty stages fill
//   even while the result register waits on a stalled receiver. When all
//   four stages are full and result.ready is low, item.ready drops.
// Reset (rst, synchronous) empties the pipeline, clears counters, integral,
//   target, direction, brake, speed and duty, and loads cfg reset values.
module motor_speed_pi_controller_unit
  import mspc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int DUTY_MAX    = 1023
) (
  input  logic              clk,
  input  logic              rst,
  mspc_item_if.sink         item,
  mspc_result_if.source     result,
  mspc_cfg_if.sink          cfg
);

  localparam int CW  = COUNT_WIDTH;
  localparam int DW  = $clog2(DUTY_MAX + 1);
  localparam int EW  = ((CW > SPEED_W) ? CW : SPEED_W) + 1;
  localparam int AW  = ((EW > IMAX_W + 1) ? EW : IMAX_W + 1) + 1;
  localparam int PPW = GAIN_W + 1 + EW;
  localparam int IPW = GAIN_W + IMAX_W;
  localparam int PW  = ((PPW > IPW + 1) ? PPW : IPW + 1) + 1;

  // configuration
  logic [GAIN_W-1:0] prop_gain;
  logic [GAIN_W-1:0] integ_gain;
  logic [IMAX_W-1:0] integral_max;

  // loop state
  logic [CW-1:0]      pulse_count;
  logic [IMAX_W-1:0]  integral_sum;
  logic [SPEED_W-1:0] speed_target;
  logic               direction;
  logic               brake_flag;
  logic [SPEED_W-1:0] last_speed;
  logic [DW-1:0]      duty_reg;

  // stage 0: input register
  logic               v0;
  cmd_t               cmd0;
  logic [SPEED_W-1:0] tspeed0;
  logic               tdir0;
  logic               breq0;

  // stage 1
  logic               v1;
  duty_op_t           op1;
  logic signed [EW-1:0] err1;
  logic [IMAX_W-1:0]  integ1;
  status_t            st1;

  // stage 2
  logic               v2;
  duty_op_t           op2;
  logic signed [PPW-1:0] pprod2;
  logic [IPW-1:0]     iprod2;
  status_t            st2;

  // stage 3: result register
  logic               v3;
  status_t            st3;

  logic r0, r1, r2, r3;
  logic adv0, adv1, adv2, adv3;

  assign r3 = !v3 || result.ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign r0 = !v0 || r1;
  assign item.ready = r0;
  assign cfg.ready  = 1'b1;

  assign adv0 = r0 && item.valid;
  assign adv1 = r1 && v0;
  assign adv2 = r2 && v1;
  assign adv3 = r3 && v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain    <= PROP_GAIN_RST;
      integ_gain   <= INTEG_GAIN_RST;
      integral_max <= IMAX_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PROP_GAIN:    prop_gain    <= cfg.data[GAIN_W-1:0];
        REG_INTEG_GAIN:   integ_gain   <= cfg.data[GAIN_W-1:0];
        REG_INTEGRAL_MAX: integral_max <= cfg.data[IMAX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 0 ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (r0) begin
      v0 <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      cmd0    <= item.command;
      tspeed0 <= item.target_speed;
      tdir0   <= item.target_direction;
      breq0   <= item.brake_request;
    end
  end

  // ---------------- stage 1: state update ----------------
  logic [EW-2:0]        tgt_ext;
  logic [EW-2:0]        cnt_ext;
  logic signed [EW-1:0] err;
  logic signed [AW-1:0] acc;
  logic [IMAX_W-1:0]    integ_clamped;

  logic [CW-1:0]        pulse_count_next;
  logic [IMAX_W-1:0]    integral_sum_next;
  logic [SPEED_W-1:0]   speed_target_next;
  logic                 direction_next;
  logic                 brake_flag_next;
  logic [SPEED_W-1:0]   last_speed_next;
  duty_op_t             op_next;

  always_comb begin
    tgt_ext = (EW-1)'(speed_target);
    cnt_ext = (EW-1)'(pulse_count);
    err = $signed({1'b0, tgt_ext}) - $signed({1'b0, cnt_ext});
    acc = $signed(AW'(err)) + $signed(AW'(integral_sum));
    if (acc[AW-1]) begin
      integ_clamped = '0;
    end else if (acc > $signed(AW'(integral_max))) begin
      integ_clamped = integral_max;
    end else begin
      integ_clamped = acc[IMAX_W-1:0];
    end
  end

  always_comb begin
    pulse_count_next  = pulse_count;
    integral_sum_next = integral_sum;
    speed_target_next = speed_target;
    direction_next    = direction;
    brake_flag_next   = brake_flag;
    last_speed_next   = last_speed;
    op_next           = DUTY_KEEP;
    case (cmd0)
      CMD_EDGE: begin
        if (pulse_count != '1) begin
          pulse_count_next = pulse_count + CW'(1);
        end
      end
      CMD_TICK: begin
        pulse_count_next = '0;
        last_speed_next  = SPEED_W'(pulse_count);
        if (brake_flag) begin
          op_next = DUTY_ZERO;
        end else begin
          integral_sum_next = integ_clamped;
          op_next           = DUTY_PI;
        end
      end
      CMD_TARGET: begin
        speed_target_next = tspeed0;
        integral_sum_next = '0;
        if (!brake_flag && (tdir0 != direction)) begin
          direction_next = tdir0;
          op_next        = DUTY_ZERO;
        end
      end
      CMD_BRAKE: begin
        brake_flag_next = breq0;
        op_next         = DUTY_ZERO;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_count  <= '0;
      integral_sum <= '0;
      speed_target <= '0;
      direction    <= 1'b0;
      brake_flag   <= 1'b0;
      last_speed   <= '0;
    end else if (adv1) begin
      pulse_count  <= pulse_count_next;
      integral_sum <= integral_sum_next;
      speed_target <= speed_target_next;
      direction    <= direction_next;
      brake_flag   <= brake_flag_next;
      last_speed   <= last_speed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (r1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      op1                <= op_next;
      err1               <= err;
      integ1             <= integ_clamped;
      st1.bridge_a       <= brake_flag_next | direction_next;
      st1.bridge_b       <= brake_flag_next | ~direction_next;
      st1.measured_speed <= last_speed_next;
      st1.braking        <= brake_flag_next;
    end
  end

  // ---------------- stage 2: products ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      op2    <= op1;
      pprod2 <= PPW'($signed({1'b0, prop_gain}) * err1);
      iprod2 <= IPW'(integ1) * IPW'(integ_gain);
      st2    <= st1;
    end
  end

  // ---------------- stage 3: sum, scale, saturate ----------------
  logic signed [PW-1:0] pi_sum;
  logic [PW-1:0]        pi_shift;
  logic [DW-1:0]        pi_duty;
  logic [DW-1:0]        duty_next;

  always_comb begin
    pi_sum   = $signed(PW'(pprod2)) + $signed(PW'(iprod2));
    pi_shift = PW'(pi_sum >>> FRAC_W);
    if (pi_sum[PW-1] || (pi_sum == '0)) begin
      pi_duty = '0;
    end else if (pi_shift > PW'(DUTY_MAX)) begin
      pi_duty = DW'(DUTY_MAX);
    end else begin
      pi_duty = pi_shift[DW-1:0];
    end
    case (op2)
      DUTY_KEEP: duty_next = duty_reg;
      DUTY_ZERO: duty_next = '0;
      DUTY_PI:   duty_next = pi_duty;
      default:   duty_next = duty_reg;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3       <= 1'b0;
      duty_reg <= '0;
    end else begin
      if (r3) begin
        v3 <= v2;
      end
      if (adv3) begin
        duty_reg <= duty_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      st3 <= st2;
    end
  end

  assign result.valid          = v3;
  assign result.pwm_duty       = duty_reg;
  assign result.bridge_a       = st3.bridge_a;
  assign result.bridge_b       = st3.bridge_b;
  assign result.measured_speed = st3.measured_speed;
  assign result.braking        = st3.braking;

endmodule

/* hw/rtl/mspc_checker.sv */
module mspc_checker
  import mspc_pkg::*;
#(
  parameter int DUTY_W = 10
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [DUTY_W-1:0]  pwm_duty,
  input logic               bridge_a,
  input logic               bridge_b,
  input logic [SPEED_W-1:0] measured_speed,
  input logic               braking
);

  localparam logic [2:0] DEPTH = 3'd4;

  logic       in_acc;
  logic       out_acc;
  logic [2:0] occ;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + 3'(in_acc) - 3'(out_acc);
    end
  end

  a_out_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pwm_duty) && $stable(measured_speed)
      && $stable(braking) && $stable(bridge_a) && $stable(bridge_b))
    else $error("result word changed while stalled");

  a_no_invented_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occ != 3'd0)
    else $error("result word with no word outstanding");

  a_full_accept_drains: assert property (@(posedge clk) disable iff (rst)
    in_acc && occ == DEPTH |-> out_acc)
    else $error("word accepted into a full pipeline");

  a_bridge_pins: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (braking ? (bridge_a && bridge_b && pwm_duty == '0)
                           : (bridge_a != bridge_b)))
    else $error("bridge pins or duty inconsistent with brake state");

endmodule

bind motor_speed_pi_controller_unit mspc_checker #(.DUTY_W(DW)) u_mspc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (item.valid),
  .in_ready       (item.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .pwm_duty       (result.pwm_duty),
  .bridge_a       (result.bridge_a),
  .bridge_b       (result.bridge_b),
  .measured_speed (result.measured_speed),
  .braking        (result.braking)
);
